@@ sv/cdbr_pkg.sv @@
// Package for the conv2d bias/ReLU unit: word types, field widths and codes.
// No dependencies.
package cdbr_pkg;

    localparam int VAL_W = 16;
    localparam int ACC_W = 48;

    typedef enum logic [1:0] {
        KIND_WEIGHT = 2'd0,
        KIND_BIAS   = 2'd1,
        KIND_PIXEL  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        REG_IMG_H  = 3'd0,
        REG_IMG_W  = 3'd1,
        REG_KER_H  = 3'd2,
        REG_KER_W  = 3'd3,
        REG_FCOUNT = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [2:0]        filter_index;
        logic [2:0]        tap_row;
        logic [2:0]        tap_col;
        logic signed [15:0] value;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  filter_id;
        logic [5:0]  out_row;
        logic [5:0]  out_col;
        logic [14:0] activation;
        logic        last;
    } out_word_t;

    // mac control from the sequencer
    typedef struct packed {
        logic clear;
        logic bias;
        logic mac;
    } mac_ctl_t;

endpackage

@@ sv/cdbr_ram.sv @@
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module cdbr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/cdbr_mac.sv @@
// Shared multiply-accumulate unit with ReLU and saturation on the sum.
// Depends on cdbr_pkg.
module cdbr_mac
    import cdbr_pkg::*;
(
    input  logic                     clk,
    input  mac_ctl_t                 ctl,
    input  logic signed [VAL_W-1:0]  a,
    input  logic signed [VAL_W-1:0]  b,
    output logic [14:0]              act
);

    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [2*VAL_W-1:0] prod;
    logic signed [ACC_W-1:0]   acc_next;
    logic [ACC_W-9:0]          q;

    assign prod = a * b;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (ctl.bias)
        begin
            acc_next = acc_reg + {{(ACC_W-VAL_W-8){a[VAL_W-1]}}, a, 8'd0};
        end
        else if (ctl.mac)
        begin
            acc_next = acc_reg + {{(ACC_W-2*VAL_W){prod[2*VAL_W-1]}}, prod};
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign q = acc_reg[ACC_W-1:8];

    always_comb
    begin
        if (acc_reg[ACC_W-1] || acc_reg == '0)
        begin
            act = '0;
        end
        else if (q > (ACC_W-8)'(32767))
        begin
            act = 15'h7FFF;
        end
        else
        begin
            act = q[14:0];
        end
    end

endmodule

@@ sv/conv2d_valid_bias_relu_unit.sv @@
// Conv2d valid/bias/ReLU top level: sequencer, weight, bias and line RAMs.
// Depends on cdbr_pkg, cdbr_ram, cdbr_mac.
// Sequence: a load is written into its RAM as it is accepted; a pixel closing a window runs,
// for each of fc filters, the states bias, taps, drain and out, waiting in out while a result is held.
// Flow: one word at a time through the shared MAC; results wait in an output register.
// Reset: async active low clears control, sizes to 48x48, 3x3, 8 filters.
module conv2d_valid_bias_relu_unit
    import cdbr_pkg::*;
#(
    parameter int IMG_MAX = 64,
    parameter int KMAX    = 5,
    parameter int FMAX    = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_word_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_word_t   out_data,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    localparam int TAPS = KMAX * KMAX;
    localparam int WDEP = FMAX * TAPS;
    localparam int LDEP = KMAX * IMG_MAX;
    localparam int WA_W = $clog2(WDEP);
    localparam int LA_W = $clog2(LDEP);
    localparam int BA_W = (FMAX > 1) ? $clog2(FMAX) : 1;
    localparam int BDEP = (FMAX > 1) ? FMAX : 2;
    localparam int P_W  = $clog2(IMG_MAX);
    localparam int S_W  = $clog2(IMG_MAX + 1);
    localparam int K_W  = $clog2(KMAX + 1);
    localparam int KI_W = (KMAX > 1) ? $clog2(KMAX) : 1;
    localparam int F_W  = $clog2(FMAX + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIAS,
        ST_TAP,
        ST_DRAIN,
        ST_OUT
    } state_t;

    state_t state_reg;
    logic [6:0] ih_cfg_reg, iw_cfg_reg;
    logic [2:0] kh_cfg_reg, kw_cfg_reg;
    logic [3:0] fc_cfg_reg;
    logic [P_W-1:0] prow_reg, pcol_reg;
    logic [KI_W-1:0] lrow_reg;
    logic [F_W-1:0] f_reg;
    logic [K_W-1:0] ta_reg, tb_reg;
    logic [1:0] drain_reg;
    logic mac_pend_reg;
    logic out_valid_reg;
    out_word_t out_reg;
    logic [P_W-1:0] r0_reg, c0_reg;

    logic [S_W-1:0] ih, iw;
    logic [K_W-1:0] kh, kw;
    logic [F_W-1:0] fc;

    always_comb
    begin
        ih = (ih_cfg_reg == 0) ? S_W'(1) :
             (ih_cfg_reg > IMG_MAX) ? S_W'(IMG_MAX) : S_W'(ih_cfg_reg);
        iw = (iw_cfg_reg == 0) ? S_W'(1) :
             (iw_cfg_reg > IMG_MAX) ? S_W'(IMG_MAX) : S_W'(iw_cfg_reg);
        kh = (kh_cfg_reg == 0) ? K_W'(1) :
             (kh_cfg_reg > KMAX) ? K_W'(KMAX) : K_W'(kh_cfg_reg);
        if (S_W'(kh) > ih)
        begin
            kh = K_W'(ih);
        end
        kw = (kw_cfg_reg == 0) ? K_W'(1) :
             (kw_cfg_reg > KMAX) ? K_W'(KMAX) : K_W'(kw_cfg_reg);
        if (S_W'(kw) > iw)
        begin
            kw = K_W'(iw);
        end
        fc = (fc_cfg_reg == 0) ? F_W'(1) :
             (fc_cfg_reg > FMAX) ? F_W'(FMAX) : F_W'(fc_cfg_reg);
    end

    logic acc_in, is_pix, w_ok, b_ok, win;
    assign acc_in = in_valid && in_ready;
    assign is_pix = in_data.kind == KIND_PIXEL;
    assign w_ok = (32'(in_data.filter_index) < FMAX) && (32'(in_data.tap_row) < KMAX)
                  && (32'(in_data.tap_col) < KMAX);
    assign b_ok = 32'(in_data.filter_index) < FMAX;
    assign win = (S_W'(prow_reg) + 1 >= S_W'(kh)) && (S_W'(pcol_reg) + 1 >= S_W'(kw));

    // RAMs
    logic w_we, b_we, l_we;
    logic [WA_W-1:0] w_waddr, w_raddr;
    logic [LA_W-1:0] l_waddr, l_raddr;
    logic [BA_W-1:0] b_waddr, b_raddr;
    logic [VAL_W-1:0] w_rd, b_rd, l_rd;

    assign w_we = acc_in && in_data.kind == KIND_WEIGHT && w_ok;
    assign b_we = acc_in && in_data.kind == KIND_BIAS && b_ok;
    assign l_we = acc_in && is_pix;
    assign w_waddr = WA_W'(32'(in_data.filter_index) * TAPS
                     + 32'(in_data.tap_row) * KMAX + 32'(in_data.tap_col));
    assign b_waddr = BA_W'(in_data.filter_index);
    assign l_waddr = LA_W'(32'(lrow_reg) * IMG_MAX + 32'(pcol_reg));

    // window row a maps to line row (r0 + a) mod KMAX
    logic [KI_W:0] lsum;
    logic [KI_W-1:0] lrd;
    logic [KI_W-1:0] r0_mod_reg;
    assign lsum = (KI_W+1)'(r0_mod_reg) + (KI_W+1)'(ta_reg);
    assign lrd = (32'(lsum) >= KMAX) ? KI_W'(32'(lsum) - KMAX) : KI_W'(lsum);
    assign w_raddr = WA_W'(32'(f_reg) * TAPS + 32'(ta_reg) * KMAX + 32'(tb_reg));
    assign l_raddr = LA_W'(32'(lrd) * IMG_MAX + 32'(c0_reg) + 32'(tb_reg));
    assign b_raddr = BA_W'(f_reg);

    cdbr_ram #(.WIDTH(VAL_W), .DEPTH(WDEP)) u_wram (
        .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(in_data.value),
        .raddr(w_raddr), .rdata(w_rd));
    cdbr_ram #(.WIDTH(VAL_W), .DEPTH(BDEP)) u_bram (
        .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(in_data.value),
        .raddr(b_raddr), .rdata(b_rd));
    cdbr_ram #(.WIDTH(VAL_W), .DEPTH(LDEP)) u_lram (
        .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(in_data.value),
        .raddr(l_raddr), .rdata(l_rd));

    mac_ctl_t ctl;
    logic bias_pend_reg;
    logic [14:0] act;
    logic signed [VAL_W-1:0] ma;

    assign ctl.clear = (state_reg == ST_BIAS) && !bias_pend_reg;
    assign ctl.bias = bias_pend_reg;
    assign ctl.mac = mac_pend_reg;
    assign ma = bias_pend_reg ? b_rd : w_rd;

    cdbr_mac u_mac (
        .clk(clk), .ctl(ctl), .a(ma), .b(l_rd), .act(act));

    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    logic tap_end;
    assign tap_end = (tb_reg + 1 == kw) && (ta_reg + 1 == kh);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ih_cfg_reg <= 7'd48;
            iw_cfg_reg <= 7'd48;
            kh_cfg_reg <= 3'd3;
            kw_cfg_reg <= 3'd3;
            fc_cfg_reg <= 4'd8;
            prow_reg <= '0;
            pcol_reg <= '0;
            lrow_reg <= '0;
            f_reg <= '0;
            ta_reg <= '0;
            tb_reg <= '0;
            drain_reg <= '0;
            mac_pend_reg <= 1'b0;
            bias_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            r0_reg <= '0;
            c0_reg <= '0;
            r0_mod_reg <= '0;
            out_reg <= '0;
        end
        else
        begin
            mac_pend_reg <= 1'b0;
            bias_pend_reg <= 1'b0;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_IMG_H:  ih_cfg_reg <= cfg_data;
                    REG_IMG_W:  iw_cfg_reg <= cfg_data;
                    REG_KER_H:  kh_cfg_reg <= cfg_data[2:0];
                    REG_KER_W:  kw_cfg_reg <= cfg_data[2:0];
                    REG_FCOUNT: fc_cfg_reg <= cfg_data[3:0];
                    default: ;
                endcase
                if (32'(cfg_index) <= 4)
                begin
                    prow_reg <= '0;
                    pcol_reg <= '0;
                    lrow_reg <= '0;
                end
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (acc_in && is_pix)
                    begin
                        if (win)
                        begin
                            r0_reg <= P_W'(S_W'(prow_reg) + 1 - S_W'(kh));
                            c0_reg <= P_W'(S_W'(pcol_reg) + 1 - S_W'(kw));
                            r0_mod_reg <= (32'(lrow_reg) + 1 >= 32'(kh))
                                ? KI_W'(32'(lrow_reg) + 1 - 32'(kh))
                                : KI_W'(32'(lrow_reg) + 1 + KMAX - 32'(kh));
                            f_reg <= '0;
                            state_reg <= ST_BIAS;
                        end
                        if (S_W'(pcol_reg) + 1 >= iw)
                        begin
                            pcol_reg <= '0;
                            if (S_W'(prow_reg) + 1 >= ih)
                            begin
                                prow_reg <= '0;
                                lrow_reg <= '0;
                            end
                            else
                            begin
                                prow_reg <= prow_reg + 1'b1;
                                lrow_reg <= (32'(lrow_reg) + 1 >= KMAX) ? '0
                                            : KI_W'(lrow_reg + 1'b1);
                            end
                        end
                        else
                        begin
                            pcol_reg <= pcol_reg + 1'b1;
                        end
                    end
                end
                ST_BIAS:
                begin
                    // clear this cycle; bias read lands next cycle
                    bias_pend_reg <= 1'b1;
                    ta_reg <= '0;
                    tb_reg <= '0;
                    state_reg <= ST_TAP;
                end
                ST_TAP:
                begin
                    mac_pend_reg <= 1'b1;
                    if (tap_end)
                    begin
                        drain_reg <= 2'd2;
                        state_reg <= ST_DRAIN;
                    end
                    else if (tb_reg + 1 == kw)
                    begin
                        tb_reg <= '0;
                        ta_reg <= ta_reg + 1'b1;
                    end
                    else
                    begin
                        tb_reg <= tb_reg + 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    drain_reg <= drain_reg - 1'b1;
                    if (drain_reg == 2'd1)
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg.filter_id <= 3'(f_reg);
                        out_reg.out_row <= 6'(r0_reg);
                        out_reg.out_col <= 6'(c0_reg);
                        out_reg.activation <= act;
                        out_reg.last <= (f_reg + 1'b1 == fc);
                        if (f_reg + 1'b1 == fc)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            f_reg <= f_reg + 1'b1;
                            state_reg <= ST_BIAS;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("accepted word while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result dropped");
    a_last_fm: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.last) |-> (F_W'(out_data.filter_id) + 1'b1 == fc))
        else $error("last on wrong filter");
    a_pix_col: assert property (@(posedge clk) disable iff (!rst_n)
        S_W'(pcol_reg) < iw || $past(cfg_we))
        else $error("column out of range");

endmodule
